### rtl/core/pirl_pkg.sv
// types and constants shared by the positional insert/remove list
// no dependencies

package pirl_pkg;

   localparam int CAPACITY   = 16;
   localparam int ELEM_BITS  = 32;
   localparam int POS_BITS   = 5;
   localparam int VALUE_BITS = 32;
   localparam int CNT_OUT_BITS = 5;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int CMP_BITS   = ((COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS) + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_BELOW,
      CELL_FROM_ABOVE
   } cell_mode_type;

   typedef struct packed {
      op_type                  operation;
      logic [POS_BITS-1:0]     position;
      logic [VALUE_BITS-1:0]   value;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic [VALUE_BITS-1:0]   read_value;
      logic [CNT_OUT_BITS-1:0] count;
   } rsp_type;

endpackage

### rtl/core/pirl_cell.sv
// one storage cell of the list: holds, loads, or takes its neighbor's entry
// depends on pirl_pkg

module pirl_cell
   import pirl_pkg::*;
(
   input  logic                 clock,
   input  cell_mode_type        mode,
   input  logic [ELEM_BITS-1:0] load_data,
   input  logic [ELEM_BITS-1:0] below_data,
   input  logic [ELEM_BITS-1:0] above_data,
   output logic [ELEM_BITS-1:0] data
);

   logic [ELEM_BITS-1:0] data_ff;
   logic [ELEM_BITS-1:0] data_in;

   always_comb begin
      unique case (mode)
         CELL_LOAD:       data_in = load_data;
         CELL_FROM_BELOW: data_in = below_data;
         CELL_FROM_ABOVE: data_in = above_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### rtl/core/positional_insert_remove_list.sv
// top level of the positional insert/remove list: control, count and a row of cells
// depends on pirl_pkg and pirl_cell
//
// An item is taken whenever start is high; busy is always low, so a new item can be
// given in every cycle. For each item every cell of the row moves at once
// (hold, load, or take the neighbor's entry), and the result appears on rsp_item with
// rsp_valid high in the cycle after the item was taken, for that one cycle only. The
// receiver must take it then. Insert fails on a full list or a position above the count;
// remove and read fail at or above the count; failed items and non-reads return zero data.

module positional_insert_remove_list
   import pirl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic [ELEM_BITS-1:0]  cell_data [CAPACITY];
   cell_mode_type         cell_mode [CAPACITY];
   logic [ELEM_BITS-1:0]  load_data;

   logic                  accept;
   logic [CMP_BITS-1:0]   pos_ext;
   logic [CMP_BITS-1:0]   cnt_ext;
   logic                  do_insert;
   logic                  do_remove;
   logic                  do_read;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign pos_ext   = CMP_BITS'(req_item.position);
   assign cnt_ext   = CMP_BITS'(count_ff);
   assign load_data = ELEM_BITS'(req_item.value);

   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_read   = 1'b0;
      if (accept) begin
         unique case (req_item.operation)
            OP_INSERT: do_insert = (cnt_ext < CMP_BITS'(CAPACITY)) && (pos_ext <= cnt_ext);
            OP_REMOVE: do_remove = pos_ext < cnt_ext;
            OP_READ:   do_read   = pos_ext < cnt_ext;
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ELEM_BITS-1:0] below;
      logic [ELEM_BITS-1:0] above;

      always_comb begin
         priority if (do_insert && CMP_BITS'(i) == pos_ext) begin
            cell_mode[i] = CELL_LOAD;
         end else if (do_insert && CMP_BITS'(i) > pos_ext && CMP_BITS'(i) <= cnt_ext) begin
            cell_mode[i] = CELL_FROM_BELOW;
         end else if (do_remove && CMP_BITS'(i) >= pos_ext
                      && CMP_BITS'(i + 1) < cnt_ext) begin
            cell_mode[i] = CELL_FROM_ABOVE;
         end else begin
            cell_mode[i] = CELL_HOLD;
         end
      end

      if (i == 0) begin : g_first
         assign below = '0;
      end else begin : g_inner_lo
         assign below = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign above = '0;
      end else begin : g_inner_hi
         assign above = cell_data[i+1];
      end

      pirl_cell u_cell (
         .clock      (clock),
         .mode       (cell_mode[i]),
         .load_data  (load_data),
         .below_data (below),
         .above_data (above),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_remove) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
      rsp_in.ok         = do_insert || do_remove || do_read;
      rsp_in.read_value = do_read ? VALUE_BITS'(cell_data[IDX_BITS'(req_item.position)])
                                  : '0;
      rsp_in.count      = CNT_OUT_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### rtl/core/pirl_checker.sv
// port-level checks for the positional insert/remove list, bound to the top level
// depends on pirl_pkg and positional_insert_remove_list

module pirl_checker
   import pirl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // every taken item gets its result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("item taken without a result");

   // no result without an item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("result without an item");

   // non-read items carry zero data
   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.operation != OP_READ) |=> rsp_item.read_value == '0)
      else $error("nonzero data on a non-read item");

   // count never exceeds capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> CMP_BITS'(rsp_item.count) <= CMP_BITS'(CAPACITY))
      else $error("count above capacity");

   // a read leaves the count as the previous result showed it
   a_read_keeps_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && start && !busy && req_item.operation == OP_READ
      |=> rsp_item.count == $past(rsp_item.count))
      else $error("read changed the count");

endmodule

bind positional_insert_remove_list pirl_checker u_pirl_checker (.*);
